@@ rtl/hfe_pkg.sv @@
// Shared constants, types and the arctangent step table of the HOG feature extractor.
// No dependencies; compiled first.
package hfe_pkg;

  // configuration register indices
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [2:0] REG_BLOCK_SIZE   = 3'd3;
  localparam logic [2:0] REG_NUM_BINS     = 3'd4;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd5;

  // fetch status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_READY = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;

  localparam logic [4:0]  CORDIC_LAST = 5'd19;    // 20 rotation steps
  localparam logic [20:0] FEATURE_CAP = 21'h100000;

  // one colour lane's central differences and squared magnitude
  typedef struct packed {
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [16:0]       mag2;
  } grad_t;

  // atan(2^-i) in units of pi/2^24
  function automatic logic [22:0] atan_step(input logic [4:0] i);
    logic [22:0] v;
    unique case (i)
      5'd0:  v = 23'd4194304;
      5'd1:  v = 23'd2476042;
      5'd2:  v = 23'd1308273;
      5'd3:  v = 23'd664100;
      5'd4:  v = 23'd333339;
      5'd5:  v = 23'd166832;
      5'd6:  v = 23'd83436;
      5'd7:  v = 23'd41721;
      5'd8:  v = 23'd20861;
      5'd9:  v = 23'd10430;
      5'd10: v = 23'd5215;
      5'd11: v = 23'd2608;
      5'd12: v = 23'd1304;
      5'd13: v = 23'd652;
      5'd14: v = 23'd326;
      5'd15: v = 23'd163;
      5'd16: v = 23'd81;
      5'd17: v = 23'd41;
      5'd18: v = 23'd20;
      5'd19: v = 23'd10;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/hfe_if.sv @@
// Valid/ready channel interfaces for the pixel/fetch input and the feature output.
// No dependencies.
interface hfe_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, req_type, red, green, blue, input ready);
  modport sink   (input valid, req_type, red, green, blue, output ready);
endinterface

interface hfe_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] feature_value;
  logic        feature_last;
  logic [1:0]  fetch_status;
  modport source (output valid, feature_value, feature_last, fetch_status, input ready);
  modport sink   (input valid, feature_value, feature_last, fetch_status, output ready);
endinterface

@@ rtl/hog_feature_extractor.sv @@
// HOG feature extractor, top level. Depends on hfe_pkg, hfe_if, hfe_grad_lane, hfe_cordic,
// hfe_isqrt and hfe_div.
//
// Load words (req_type 0) stream an image in raster order; fetch words (req_type 1) return
// one feature each once the last pixel is in. One word is in flight at a time. A border pixel
// is only stored; an interior pixel takes three row-store reads, a root for the magnitude (the
// 20-step CORDIC angle runs beside it), two bin multiplies and two read-modify-write passes on
// the histogram memory. The first pixel of each image is followed by a clearing pass over all
// 65536 histogram words, during which no word is taken. A fetch of a feature reads one
// histogram word and divides it by the block norm; the first fetch of each block also walks
// the block's block_size^2 * num_bins bins and takes a root for that norm. After reset and
// after each register write the cell and block grid is derived anew, during which no word is
// taken. A finished feature waits in the output register while the next word runs.
module hog_feature_extractor (
  input  logic       clk,
  input  logic       rst_n,
  hfe_in_if.sink     in_s,
  hfe_out_if.source  out_m,
  input  logic       cfg_we,
  input  logic [2:0] cfg_idx,
  input  logic [8:0] cfg_data
);
  import hfe_pkg::*;

  // sequencer codes
  localparam logic [5:0] S_GEO_CX  = 6'd0,  S_W_CX   = 6'd1,  S_GEO_CY  = 6'd2;
  localparam logic [5:0] S_W_CY    = 6'd3,  S_GEO_CAP = 6'd4, S_W_CAP   = 6'd5;
  localparam logic [5:0] S_GEO_B   = 6'd6,  S_GEO_T1 = 6'd7,  S_GEO_T2  = 6'd8;
  localparam logic [5:0] S_IDLE    = 6'd9,  S_P_RD0  = 6'd10, S_P_RD1   = 6'd11;
  localparam logic [5:0] S_P_RD2   = 6'd12, S_P_RD3  = 6'd13, S_P_SEL   = 6'd14;
  localparam logic [5:0] S_P_GO    = 6'd15, S_P_W    = 6'd16, S_P_BIN   = 6'd17;
  localparam logic [5:0] S_P_W0    = 6'd18, S_P_W1   = 6'd19, S_H_RD0   = 6'd20;
  localparam logic [5:0] S_H_WR0   = 6'd21, S_H_RD1  = 6'd22, S_H_WR1   = 6'd23;
  localparam logic [5:0] S_P_ADV   = 6'd24, S_CLEAR  = 6'd25, S_N_ADR   = 6'd26;
  localparam logic [5:0] S_N_RD    = 6'd27, S_N_SQ   = 6'd28, S_N_ACC   = 6'd29;
  localparam logic [5:0] S_N_GO    = 6'd30, S_N_W    = 6'd31, S_F_ADR   = 6'd32;
  localparam logic [5:0] S_F_RD    = 6'd33, S_F_DIV  = 6'd34, S_F_W     = 6'd35;
  localparam logic [5:0] S_EMIT    = 6'd36;

  logic [5:0] state_r;

  // raw registers and their clamped values
  logic [8:0] width_r, height_r;
  logic [6:0] csize_r;
  logic [3:0] bsize_r;
  logic [4:0] nbins_r;
  logic       cmode_r;
  logic [8:0] gw, gh;
  logic [6:0] gcs;
  logic [3:0] gbs;
  logic [4:0] gnb;

  assign gw  = width_r < 9'd3 ? 9'd3 : (width_r > 9'd256 ? 9'd256 : width_r);
  assign gh  = height_r < 9'd3 ? 9'd3 : (height_r > 9'd256 ? 9'd256 : height_r);
  assign gcs = csize_r == 7'd0 ? 7'd1 : (csize_r > 7'd64 ? 7'd64 : csize_r);
  assign gbs = bsize_r == 4'd0 ? 4'd1 : (bsize_r > 4'd8 ? 4'd8 : bsize_r);
  assign gnb = nbins_r < 5'd2 ? 5'd2 : (nbins_r > 5'd16 ? 5'd16 : nbins_r);

  // grid
  logic [7:0]  cx_r, cy_r, bx_r, by_r;
  logic [10:0] pblk_r;
  logic [15:0] bxby_r;
  logic [20:0] total_r;
  logic [26:0] tot_full;
  assign tot_full = 27'(bxby_r * pblk_r);

  // pixel position and cell tracking (cj for column c-1, ci for row r-2)
  logic [7:0] col_r, row_r, cj_r, ci_r;
  logic [5:0] cjo_r, cio_r;
  logic       first_r, img_ready_r;
  logic [7:0] pr_r, pg_r, pb_r;
  logic       interior;

  assign interior = (row_r >= 8'd2) && (col_r >= 8'd1) && ({1'b0, col_r} + 9'd1 < gw)
                    && (ci_r < cy_r) && (cj_r < cx_r);

  // row store: two pixel rows, packed {blue, green, red}
  logic [23:0] rs_mem [512];
  logic [23:0] rq_r, above_r, left_r, right_r;
  logic [8:0]  rs_ra;
  logic        rs_we;

  always_comb begin
    unique case (state_r)
      S_P_RD1: rs_ra = {~row_r[0], col_r - 8'd1};
      S_P_RD2: rs_ra = {~row_r[0], col_r + 8'd1};
      default: rs_ra = {row_r[0], col_r};
    endcase
  end
  assign rs_we = (state_r == S_P_ADV);

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[{row_r[0], col_r}] <= {pb_r, pg_r, pr_r};
    rq_r <= rs_mem[rs_ra];
  end

  // colour lanes and the strongest-channel merge
  grad_t g_red, g_grn, g_blu, gsel;

  hfe_grad_lane u_lane_r (.cur(pr_r), .above(above_r[7:0]), .left(left_r[7:0]),
                          .right(right_r[7:0]), .g(g_red));
  hfe_grad_lane u_lane_g (.cur(pg_r), .above(above_r[15:8]), .left(left_r[15:8]),
                          .right(right_r[15:8]), .g(g_grn));
  hfe_grad_lane u_lane_b (.cur(pb_r), .above(above_r[23:16]), .left(left_r[23:16]),
                          .right(right_r[23:16]), .g(g_blu));

  always_comb begin
    gsel = g_red;
    if (cmode_r) begin
      // green beats blue on a tie, red keeps any tie with red
      if (g_grn.mag2 >= g_blu.mag2 && g_grn.mag2 > g_red.mag2) gsel = g_grn;
      else if (g_blu.mag2 >= g_grn.mag2 && g_blu.mag2 > g_red.mag2) gsel = g_blu;
    end
  end

  // iterative units; the root and the divider are shared
  logic        sq_start, sq_busy, co_start, co_busy, dv_start, dv_busy;
  logic [63:0] sq_val;
  logic [31:0] sq_root, dv_den;
  logic [47:0] dv_num, dv_quo;
  logic [23:0] co_ang;
  logic [7:0]  adx, ady;
  logic        dxneg_r;
  grad_t       gm_r;
  logic [63:0] sum_r, sq_r;
  logic [31:0] norm_r, hq_r;

  assign adx = gm_r.dx[8] ? 8'(-gm_r.dx) : gm_r.dx[7:0];
  assign ady = gm_r.dy[8] ? 8'(-gm_r.dy) : gm_r.dy[7:0];

  assign sq_start = (state_r == S_P_GO) || (state_r == S_N_GO);
  assign sq_val   = (state_r == S_P_GO) ? {31'b0, gm_r.mag2, 16'b0} : sum_r;
  assign co_start = (state_r == S_P_GO);
  assign dv_start = (state_r == S_GEO_CX) || (state_r == S_GEO_CY)
                    || (state_r == S_F_DIV) || ((state_r == S_GEO_CAP) && (cx_r != 8'd0));

  always_comb begin
    unique case (state_r)
      S_F_DIV: begin
        dv_num = {hq_r, 16'b0};
        dv_den = (norm_r == 32'd0) ? 32'd1 : norm_r;
      end
      S_GEO_CAP: begin
        dv_num = 48'd4096;
        dv_den = {24'b0, cx_r};
      end
      S_GEO_CY: begin
        dv_num = 48'(gh - 9'd2);
        dv_den = {25'b0, gcs};
      end
      default: begin
        dv_num = 48'(gw - 9'd2);
        dv_den = {25'b0, gcs};
      end
    endcase
  end

  hfe_isqrt  u_sqrt (.clk, .rst_n, .start(sq_start), .val(sq_val), .busy(sq_busy),
                     .root(sq_root));
  hfe_cordic u_cord (.clk, .rst_n, .start(co_start), .ax(adx), .ay(ady), .busy(co_busy),
                     .angle(co_ang));
  hfe_div    u_div  (.clk, .rst_n, .start(dv_start), .num(dv_num), .den(dv_den),
                     .busy(dv_busy), .quo(dv_quo));

  // bin split
  logic [16:0] mag_r;
  logic [15:0] pos_r;
  logic [24:0] ang25;
  logic [29:0] pos_full;
  logic [17:0] pos18;
  logic [11:0] bf;
  logic [3:0]  bb, b0, b1, nbm1;
  logic [12:0] w0, w1;
  logic [3:0]  bin0_r, bin1_r;
  logic [17:0] add0_r, add1_r;
  logic [29:0] prod0, prod1;

  assign ang25    = dxneg_r ? 25'h100_0000 - {1'b0, co_ang} : {1'b0, co_ang};
  assign pos_full = 30'(ang25 * gnb);
  assign pos18    = pos_full[29:12];
  assign nbm1     = 4'(gnb - 5'd1);
  assign bf       = pos_r[11:0];
  assign bb       = pos_r[15:12];

  always_comb begin
    if (bf < 12'd2048) begin
      b1 = bb;
      w1 = 13'd2048 + {1'b0, bf};
      w0 = 13'd2048 - {1'b0, bf};
      b0 = (bb == 4'd0) ? nbm1 : bb - 4'd1;
    end else begin
      b0 = bb;
      w0 = 13'd6144 - {1'b0, bf};
      w1 = {1'b0, bf} - 13'd2048;
      b1 = ({1'b0, bb} + 5'd1 >= gnb) ? 4'd0 : bb + 4'd1;
    end
  end

  assign prod0 = 30'(w0 * mag_r);
  assign prod1 = 30'(w1 * mag_r);

  // histogram memory: 4096 cells x 16 bins, Q24.8
  logic [31:0] hmem [65536];
  logic [15:0] h_adr, clr_r;
  logic        h_we;
  logic [31:0] h_wd;
  logic [32:0] hsum0, hsum1;
  logic [11:0] cell_r, frow_r, ncell, fcell;

  // fetch walk: block (bi, bj), cell (k, l), bin m; norm walk nk, nl, nm
  logic [7:0]  bi_r, bj_r;
  logic [2:0]  k_r, l_r, nk_r, nl_r;
  logic [3:0]  m_r, nm_r;
  logic [20:0] cursor_r;
  logic [64:0] nsum;

  assign hsum0 = {1'b0, hq_r} + {15'b0, add0_r};
  assign hsum1 = {1'b0, hq_r} + {15'b0, add1_r};
  assign ncell = frow_r + {4'b0, bj_r} + {9'b0, nl_r};
  assign fcell = frow_r + {4'b0, bj_r} + {9'b0, l_r};
  assign nsum  = {1'b0, sum_r} + {1'b0, sq_r};

  always_comb begin
    h_we = 1'b0;
    h_wd = '0;
    unique case (state_r)
      S_CLEAR: begin
        h_adr = clr_r;
        h_we  = 1'b1;
      end
      S_H_RD0: h_adr = {cell_r, bin0_r};
      S_H_WR0: begin
        h_adr = {cell_r, bin0_r};
        h_we  = 1'b1;
        h_wd  = hsum0[32] ? '1 : hsum0[31:0];
      end
      S_H_RD1: h_adr = {cell_r, bin1_r};
      S_H_WR1: begin
        h_adr = {cell_r, bin1_r};
        h_we  = 1'b1;
        h_wd  = hsum1[32] ? '1 : hsum1[31:0];
      end
      S_N_RD:  h_adr = {ncell, nm_r};
      S_F_RD:  h_adr = {fcell, m_r};
      default: h_adr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_adr] <= h_wd;
    hq_r <= hmem[h_adr];
  end

  // output register
  logic        ov_r, olast_r, res_last_r;
  logic [15:0] oval_r, res_val_r;
  logic [1:0]  ostat_r, res_stat_r;
  logic        in_acc, cfg_hit;

  assign in_s.ready          = (state_r == S_IDLE);
  assign in_acc              = in_s.valid && in_s.ready;
  assign out_m.valid         = ov_r;
  assign out_m.feature_value = oval_r;
  assign out_m.feature_last  = olast_r;
  assign out_m.fetch_status  = ostat_r;
  assign cfg_hit             = cfg_we && (cfg_idx <= REG_COLOR_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_GEO_CX;
      width_r     <= 9'd64;
      height_r    <= 9'd128;
      csize_r     <= 7'd6;
      bsize_r     <= 4'd3;
      nbins_r     <= 5'd9;
      cmode_r     <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      cj_r        <= '0;
      cjo_r       <= '0;
      ci_r        <= '0;
      cio_r       <= '0;
      first_r     <= 1'b0;
      img_ready_r <= 1'b0;
      cursor_r    <= '0;
      bi_r        <= '0;
      bj_r        <= '0;
      k_r         <= '0;
      l_r         <= '0;
      m_r         <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (ov_r && out_m.ready) ov_r <= 1'b0;

      unique case (state_r)
        // grid derivation
        S_GEO_CX:  state_r <= S_W_CX;
        S_W_CX: if (!dv_busy) begin
          cx_r    <= dv_quo[7:0];
          state_r <= S_GEO_CY;
        end
        S_GEO_CY:  state_r <= S_W_CY;
        S_W_CY: if (!dv_busy) begin
          cy_r    <= dv_quo[7:0];
          state_r <= S_GEO_CAP;
        end
        S_GEO_CAP: begin
          if (cx_r == 8'd0) begin
            cy_r    <= '0;
            state_r <= S_GEO_B;
          end else begin
            state_r <= S_W_CAP;
          end
        end
        S_W_CAP: if (!dv_busy) begin
          // cell rows capped so the grid fits the cell store
          if (dv_quo[12:0] < {5'b0, cy_r}) cy_r <= dv_quo[7:0];
          state_r <= S_GEO_B;
        end
        S_GEO_B: begin
          bx_r    <= (cx_r >= {4'b0, gbs}) ? cx_r - {4'b0, gbs} + 8'd1 : 8'd0;
          by_r    <= (cy_r >= {4'b0, gbs}) ? cy_r - {4'b0, gbs} + 8'd1 : 8'd0;
          pblk_r  <= 11'(gbs * gbs * gnb);
          state_r <= S_GEO_T1;
        end
        S_GEO_T1: begin
          bxby_r  <= 16'(bx_r * by_r);
          state_r <= S_GEO_T2;
        end
        S_GEO_T2: begin
          total_r <= (tot_full > 27'(FEATURE_CAP)) ? FEATURE_CAP : tot_full[20:0];
          state_r <= S_IDLE;
        end

        S_IDLE: if (in_acc) begin
          if (!in_s.req_type) begin
            pr_r    <= in_s.red;
            pg_r    <= in_s.green;
            pb_r    <= in_s.blue;
            first_r <= (row_r == 8'd0) && (col_r == 8'd0);
            if (row_r == 8'd0 && col_r == 8'd0) begin
              img_ready_r <= 1'b0;
              cursor_r    <= '0;
              bi_r        <= '0;
              bj_r        <= '0;
              k_r         <= '0;
              l_r         <= '0;
              m_r         <= '0;
            end
            state_r <= interior ? S_P_RD0 : S_P_ADV;
          end else begin
            res_val_r  <= '0;
            res_last_r <= 1'b0;
            if (!img_ready_r) begin
              res_stat_r <= STAT_NOT_READY;
              state_r    <= S_EMIT;
            end else if (cursor_r >= total_r) begin
              res_stat_r <= STAT_EMPTY;
              state_r    <= S_EMIT;
            end else if (k_r == 3'd0 && l_r == 3'd0 && m_r == 4'd0) begin
              nk_r    <= '0;
              nl_r    <= '0;
              nm_r    <= '0;
              sum_r   <= 64'd65536;
              state_r <= S_N_ADR;
            end else begin
              state_r <= S_F_ADR;
            end
          end
        end

        // interior pixel
        S_P_RD0: begin
          frow_r  <= 12'(ci_r * cx_r);
          state_r <= S_P_RD1;
        end
        S_P_RD1: begin
          above_r <= rq_r;
          cell_r  <= frow_r + {4'b0, cj_r};
          state_r <= S_P_RD2;
        end
        S_P_RD2: begin
          left_r  <= rq_r;
          state_r <= S_P_RD3;
        end
        S_P_RD3: begin
          right_r <= rq_r;
          state_r <= S_P_SEL;
        end
        S_P_SEL: begin
          gm_r    <= gsel;
          state_r <= S_P_GO;
        end
        S_P_GO: begin
          dxneg_r <= gm_r.dx[8];
          state_r <= S_P_W;
        end
        S_P_W: if (!sq_busy && !co_busy) begin
          mag_r   <= sq_root[16:0];
          state_r <= S_P_BIN;
        end
        S_P_BIN: begin
          // a position at or past the top bin wraps to bin zero
          pos_r   <= (pos18 >= {1'b0, gnb, 12'b0}) ? 16'd0 : pos18[15:0];
          state_r <= S_P_W0;
        end
        S_P_W0: begin
          bin0_r  <= b0;
          bin1_r  <= b1;
          add0_r  <= prod0[29:12];
          state_r <= S_P_W1;
        end
        S_P_W1: begin
          add1_r  <= prod1[29:12];
          state_r <= S_H_RD0;
        end
        S_H_RD0: state_r <= S_H_WR0;
        S_H_WR0: state_r <= S_H_RD1;
        S_H_RD1: state_r <= S_H_WR1;
        S_H_WR1: state_r <= S_P_ADV;

        S_P_ADV: begin
          if ({1'b0, col_r} + 9'd1 >= gw) begin
            col_r <= '0;
            cj_r  <= '0;
            cjo_r <= '0;
            if ({1'b0, row_r} + 9'd1 >= gh) begin
              row_r       <= '0;
              ci_r        <= '0;
              cio_r       <= '0;
              img_ready_r <= 1'b1;
            end else begin
              row_r <= row_r + 8'd1;
              if (row_r == 8'd1) begin
                ci_r  <= '0;
                cio_r <= '0;
              end else if (row_r >= 8'd2) begin
                if ({1'b0, cio_r} + 7'd1 == gcs) begin
                  cio_r <= '0;
                  ci_r  <= ci_r + 8'd1;
                end else begin
                  cio_r <= cio_r + 6'd1;
                end
              end
            end
          end else begin
            col_r <= col_r + 8'd1;
            if (col_r == 8'd0) begin
              cj_r  <= '0;
              cjo_r <= '0;
            end else if ({1'b0, cjo_r} + 7'd1 == gcs) begin
              cjo_r <= '0;
              cj_r  <= cj_r + 8'd1;
            end else begin
              cjo_r <= cjo_r + 6'd1;
            end
          end
          clr_r   <= '0;
          state_r <= first_r ? S_CLEAR : S_IDLE;
        end

        // new image: sweep the histograms to zero
        S_CLEAR: begin
          clr_r <= clr_r + 16'd1;
          if (clr_r == 16'hFFFF) state_r <= S_IDLE;
        end

        // block norm walk
        S_N_ADR: begin
          frow_r  <= 12'(({1'b0, bi_r} + {6'b0, nk_r}) * cx_r);
          state_r <= S_N_RD;
        end
        S_N_RD:  state_r <= S_N_SQ;
        S_N_SQ: begin
          sq_r    <= 64'(hq_r * hq_r);
          state_r <= S_N_ACC;
        end
        S_N_ACC: begin
          sum_r   <= nsum[64] ? '1 : nsum[63:0];
          state_r <= S_N_ADR;
          if ({1'b0, nm_r} + 5'd1 == gnb) begin
            nm_r <= '0;
            if ({1'b0, nl_r} + 4'd1 == gbs) begin
              nl_r <= '0;
              if ({1'b0, nk_r} + 4'd1 == gbs) begin
                nk_r    <= '0;
                state_r <= S_N_GO;
              end else begin
                nk_r <= nk_r + 3'd1;
              end
            end else begin
              nl_r <= nl_r + 3'd1;
            end
          end else begin
            nm_r <= nm_r + 4'd1;
          end
        end
        S_N_GO:  state_r <= S_N_W;
        S_N_W: if (!sq_busy) begin
          norm_r  <= sq_root;
          state_r <= S_F_ADR;
        end

        // one feature
        S_F_ADR: begin
          frow_r  <= 12'(({1'b0, bi_r} + {6'b0, k_r}) * cx_r);
          state_r <= S_F_RD;
        end
        S_F_RD:  state_r <= S_F_DIV;
        S_F_DIV: state_r <= S_F_W;
        S_F_W: if (!dv_busy) begin
          res_val_r  <= (dv_quo[47:16] != 32'd0) ? 16'hFFFF : dv_quo[15:0];
          res_last_r <= (cursor_r + 21'd1 == total_r);
          res_stat_r <= STAT_OK;
          cursor_r   <= cursor_r + 21'd1;
          if ({1'b0, m_r} + 5'd1 == gnb) begin
            m_r <= '0;
            if ({1'b0, l_r} + 4'd1 == gbs) begin
              l_r <= '0;
              if ({1'b0, k_r} + 4'd1 == gbs) begin
                k_r <= '0;
                if (bj_r + 8'd1 == bx_r) begin
                  bj_r <= '0;
                  bi_r <= bi_r + 8'd1;
                end else begin
                  bj_r <= bj_r + 8'd1;
                end
              end else begin
                k_r <= k_r + 3'd1;
              end
            end else begin
              l_r <= l_r + 3'd1;
            end
          end else begin
            m_r <= m_r + 4'd1;
          end
          state_r <= S_EMIT;
        end

        S_EMIT: if (!ov_r || out_m.ready) begin
          ov_r    <= 1'b1;
          oval_r  <= res_val_r;
          olast_r <= res_last_r;
          ostat_r <= res_stat_r;
          state_r <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase

      // register write: restart the image and rederive the grid
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          REG_IMAGE_HEIGHT: height_r <= cfg_data;
          REG_CELL_SIZE:    csize_r  <= cfg_data[6:0];
          REG_BLOCK_SIZE:   bsize_r  <= cfg_data[3:0];
          REG_NUM_BINS:     nbins_r  <= cfg_data[4:0];
          REG_COLOR_MODE:   cmode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        col_r       <= '0;
        row_r       <= '0;
        cj_r        <= '0;
        cjo_r       <= '0;
        ci_r        <= '0;
        cio_r       <= '0;
        img_ready_r <= 1'b0;
        cursor_r    <= '0;
        bi_r        <= '0;
        bj_r        <= '0;
        k_r         <= '0;
        l_r         <= '0;
        m_r         <= '0;
        state_r     <= S_GEO_CX;
      end
    end
  end
endmodule

@@ rtl/hfe_grad_lane.sv @@
// One colour lane: central differences and squared gradient magnitude.
// Depends on hfe_pkg (grad_t).
module hfe_grad_lane (
  input  logic [7:0]     cur,
  input  logic [7:0]     above,
  input  logic [7:0]     left,
  input  logic [7:0]     right,
  output hfe_pkg::grad_t g
);
  import hfe_pkg::*;

  logic signed [8:0]  dx, dy;
  logic signed [17:0] sqx, sqy;

  assign dx  = $signed({1'b0, right}) - $signed({1'b0, left});
  assign dy  = $signed({1'b0, cur}) - $signed({1'b0, above});
  assign sqx = 18'(dx * dx);
  assign sqy = 18'(dy * dy);

  assign g.dx   = dx;
  assign g.dy   = dy;
  assign g.mag2 = {1'b0, sqx[15:0]} + {1'b0, sqy[15:0]};
endmodule

@@ rtl/hfe_cordic.sv @@
// Iterative vectoring CORDIC: first-quadrant angle of (ax, ay), one step a cycle.
// Depends on hfe_pkg (atan_step, CORDIC_LAST).
module hfe_cordic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  ax,
  input  logic [7:0]  ay,
  output logic        busy,
  output logic [23:0] angle
);
  import hfe_pkg::*;

  logic signed [35:0] x_r, y_r, xs, ys;
  logic signed [25:0] z_r, t;
  logic [4:0]         i_r;
  logic               busy_r;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign t  = $signed({3'b0, atan_step(i_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      if (ay == 8'd0) begin
        z_r    <= '0;
        busy_r <= 1'b0;
      end else if (ax == 8'd0) begin
        z_r    <= 26'sd8388608;
        busy_r <= 1'b0;
      end else begin
        x_r    <= $signed({4'b0, ax, 24'b0});
        y_r    <= $signed({4'b0, ay, 24'b0});
        z_r    <= '0;
        i_r    <= '0;
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (y_r > 36'sd0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + t;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - t;
      end
      i_r <= i_r + 5'd1;
      if (i_r == CORDIC_LAST) busy_r <= 1'b0;
    end
  end

  assign busy  = busy_r;
  assign angle = z_r[25] ? 24'd0 : (z_r > 26'sd8388608 ? 24'd8388608 : z_r[23:0]);
endmodule

@@ rtl/hfe_isqrt.sv @@
// Iterative integer square root of a 64-bit word, two radicand bits a cycle.
// No package dependencies.
module hfe_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v_r, r_r, b_r, rb;
  logic [4:0]  cnt_r;
  logic        busy_r;

  assign rb = r_r + b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      v_r    <= val;
      r_r    <= '0;
      b_r    <= 64'h4000_0000_0000_0000;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (v_r >= rb) begin
        v_r <= v_r - rb;
        r_r <= (r_r >> 1) + b_r;
      end else begin
        r_r <= r_r >> 1;
      end
      b_r   <= b_r >> 2;
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign root = r_r[31:0];
endmodule

@@ rtl/hfe_div.sv @@
// Restoring divider, 48-bit dividend by 32-bit divisor, one quotient bit a cycle.
// No package dependencies.
module hfe_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [47:0] quo
);
  logic [47:0] q_r;
  logic [31:0] rem_r, den_r;
  logic [32:0] trial, diff;
  logic [5:0]  cnt_r;
  logic        busy_r, ge;

  assign trial = {rem_r, q_r[47]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      q_r    <= num;
      rem_r  <= '0;
      den_r  <= den;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      q_r   <= {q_r[46:0], ge};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd47) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quo  = q_r;
endmodule
